// ===== rtl/core/bced_pkg.sv =====
// Package with shared types, codes and constants of the button click event detector.
package bced_pkg;

    // Phase codes of the button state machine
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PRESSED = 2'd1;
    localparam logic [1:0] PH_LONG    = 2'd2;
    localparam logic [1:0] PH_WAIT    = 2'd3;

    // Event codes
    localparam logic [2:0] EV_DOWN   = 3'd0;
    localparam logic [2:0] EV_LONG   = 3'd1;
    localparam logic [2:0] EV_UP     = 3'd2;
    localparam logic [2:0] EV_SINGLE = 3'd3;
    localparam logic [2:0] EV_DOUBLE = 3'd4;
    localparam logic [2:0] EV_TRIPLE = 3'd5;
    localparam logic [2:0] EV_REPEAT = 3'd6;

    // Register indexes (word address)
    localparam logic [2:0] REG_ACTIVE_LEVEL   = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE_TICKS = 3'd1;
    localparam logic [2:0] REG_LONG_PRESS     = 3'd2;
    localparam logic [2:0] REG_CLICK_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_EVENT_ENABLE   = 3'd4;

    // Saturation limits of the counters
    localparam logic [16:0] HOLD_MAX = 17'h1FFFF;
    localparam logic [8:0]  GAP_MAX  = 9'h1FF;

    // Event queue depth and its index / fill widths
    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_AW    = 2;
    localparam int EVQ_CW    = 3;

    typedef struct packed {
        logic        active_level;
        logic [7:0]  debounce_ticks;
        logic [15:0] long_press_ticks;
        logic [7:0]  click_timeout_ticks;
        logic [6:0]  event_enable_mask;
    } cfg_t;

    typedef struct packed {
        logic [2:0] code;
        logic       level;
        logic       last;
    } ev_t;

    // Events produced by one tick, compacted into first / second
    typedef struct packed {
        logic [1:0] cnt;
        ev_t        first;
        ev_t        second;
    } ev_pair_t;

    typedef struct packed {
        logic [EVQ_CW-1:0] level;
    } evq_status_t;

endpackage

// ===== rtl/core/bced_regs.sv =====
// Configuration register file with an APB-style write and read port.
module bced_regs
    import bced_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    // Update the addressed register on a write transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_ACTIVE_LEVEL:   cfg_reg.active_level        <= pwdata[0];
                REG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks      <= pwdata[7:0];
                REG_LONG_PRESS:     cfg_reg.long_press_ticks    <= pwdata[15:0];
                REG_CLICK_TIMEOUT:  cfg_reg.click_timeout_ticks <= pwdata[7:0];
                REG_EVENT_ENABLE:   cfg_reg.event_enable_mask   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register on a read
    always_comb begin
        unique case (paddr[4:2])
            REG_ACTIVE_LEVEL:   prdata = {31'd0, cfg_reg.active_level};
            REG_DEBOUNCE_TICKS: prdata = {24'd0, cfg_reg.debounce_ticks};
            REG_LONG_PRESS:     prdata = {16'd0, cfg_reg.long_press_ticks};
            REG_CLICK_TIMEOUT:  prdata = {24'd0, cfg_reg.click_timeout_ticks};
            REG_EVENT_ENABLE:   prdata = {25'd0, cfg_reg.event_enable_mask};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/core/bced_fsm.sv =====
// Debounce and phase state machine: one tick per cycle while step is high, up to two events per tick.
module bced_fsm
    import bced_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  logic     pin_level,
    input  cfg_t     cfg,
    output ev_pair_t evs
);

    logic [1:0]  phase_reg, phase_next, phase_mid;
    logic        pressed_reg, pressed_next;
    logic [7:0]  deb_reg, deb_next;
    logic [16:0] hold_reg, hold_next;
    logic [1:0]  click_reg, click_next;
    logic [8:0]  gap_reg, gap_next;

    logic        act;
    logic [7:0]  ctmo;
    logic [8:0]  gap_inc;
    logic [6:0]  en;
    logic        e0_v, e1_v;
    logic [2:0]  c0, c1, click_code;

    assign en = cfg.event_enable_mask;

    always_comb begin
        act  = (pin_level == cfg.active_level);
        ctmo = ({8'd0, cfg.click_timeout_ticks} < cfg.long_press_ticks) ?
               cfg.click_timeout_ticks : cfg.long_press_ticks[7:0];
        gap_inc = (gap_reg != GAP_MAX) ? gap_reg + 9'd1 : gap_reg;

        phase_mid    = phase_reg;
        pressed_next = pressed_reg;
        deb_next     = deb_reg;
        hold_next    = hold_reg;
        click_next   = click_reg;
        gap_next     = gap_reg;
        e0_v = 1'b0;
        e1_v = 1'b0;
        c0   = EV_DOWN;
        c1   = EV_LONG;

        // Debounce the active level
        if (act) begin
            if (deb_reg < cfg.debounce_ticks) begin
                deb_next = deb_reg + 8'd1;
            end else if (!pressed_reg) begin
                phase_mid    = PH_PRESSED;
                pressed_next = 1'b1;
                deb_next     = 8'd0;
            end
        end else begin
            deb_next     = 8'd0;
            pressed_next = 1'b0;
        end

        // Select the click event with its fallbacks
        case (click_reg)
            2'd0:    click_code = en[EV_SINGLE] ? EV_SINGLE : EV_UP;
            2'd1:    click_code = en[EV_DOUBLE] ? EV_DOUBLE : EV_SINGLE;
            2'd2:    click_code = en[EV_TRIPLE] ? EV_TRIPLE :
                                  (en[EV_DOUBLE] ? EV_DOUBLE : EV_SINGLE);
            default: click_code = EV_REPEAT;
        endcase

        // Advance the phase
        phase_next = phase_mid;
        unique case (phase_mid)
            PH_IDLE: begin
                pressed_next = 1'b0;
                click_next   = 2'd0;
            end
            PH_PRESSED: begin
                if (act) begin
                    e0_v = en[EV_DOWN];
                    c0   = EV_DOWN;
                    if (hold_reg != HOLD_MAX) begin
                        hold_next = hold_reg + 17'd1;
                    end
                    if (hold_reg > {1'b0, cfg.long_press_ticks}) begin
                        e1_v       = en[EV_LONG];
                        c1         = EV_LONG;
                        phase_next = PH_LONG;
                    end
                end else if (hold_reg < {1'b0, cfg.long_press_ticks}) begin
                    phase_next = PH_WAIT;
                end else begin
                    e0_v       = en[EV_UP];
                    c0         = EV_UP;
                    phase_next = PH_IDLE;
                    hold_next  = 17'd0;
                end
            end
            PH_LONG: begin
                if (!act) begin
                    e0_v       = en[EV_UP];
                    c0         = EV_UP;
                    phase_next = PH_IDLE;
                    hold_next  = 17'd0;
                end
            end
            PH_WAIT: begin
                gap_next = gap_inc;
                if (act) begin
                    if (click_reg != 2'd3) begin
                        click_next = click_reg + 2'd1;
                    end
                    phase_next   = PH_PRESSED;
                    hold_next    = 17'd0;
                    gap_next     = 9'd0;
                    pressed_next = 1'b1;
                end else if (gap_inc > {1'b0, ctmo}) begin
                    e0_v       = en[click_code];
                    c0         = click_code;
                    phase_next = PH_IDLE;
                    hold_next  = 17'd0;
                    click_next = 2'd0;
                    gap_next   = 9'd0;
                end
            end
            default: ;
        endcase

        // Compact the enabled events and mark the last one of the tick
        evs = '0;
        evs.first.level  = pin_level;
        evs.second.level = pin_level;
        if (step) begin
            if (e0_v && e1_v) begin
                evs.cnt         = 2'd2;
                evs.first.code  = c0;
                evs.second.code = c1;
                evs.second.last = 1'b1;
            end else if (e0_v || e1_v) begin
                evs.cnt        = 2'd1;
                evs.first.code = e0_v ? c0 : c1;
                evs.first.last = 1'b1;
            end
        end
    end

    // Hold state unless a tick is accepted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            pressed_reg <= 1'b0;
            deb_reg     <= 8'd0;
            hold_reg    <= 17'd0;
            click_reg   <= 2'd0;
            gap_reg     <= 9'd0;
        end else if (step) begin
            phase_reg   <= phase_next;
            pressed_reg <= pressed_next;
            deb_reg     <= deb_next;
            hold_reg    <= hold_next;
            click_reg   <= click_next;
            gap_reg     <= gap_next;
        end
    end

endmodule

// ===== rtl/core/bced_evq.sv =====
// Four-entry event queue: takes up to two events a cycle, delivers one.
module bced_evq
    import bced_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  ev_pair_t    push,
    input  logic        pop,
    output ev_t         head,
    output evq_status_t status
);

    ev_t               mem_reg [EVQ_DEPTH];
    logic [EVQ_AW-1:0] wr_reg, rd_reg;
    logic [EVQ_CW-1:0] cnt_reg;
    logic [EVQ_AW-1:0] wr_plus1;

    assign wr_plus1     = wr_reg + EVQ_AW'(1);
    assign head         = mem_reg[rd_reg];
    assign status.level = cnt_reg;

    // Store pushed events
    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem_reg[wr_reg] <= push.first;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[wr_plus1] <= push.second;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + EVQ_AW'(push.cnt);
            rd_reg  <= rd_reg + EVQ_AW'(pop);
            cnt_reg <= cnt_reg + EVQ_CW'(push.cnt) - EVQ_CW'(pop);
        end
    end

endmodule

// ===== rtl/core/button_click_event_detector_top.sv =====
// Top level of the button click event detector.
//
//  channel | ports                  | handshake     | payload
//  --------+------------------------+---------------+-----------------------------------
//  input   | s_valid / s_ready      | valid, ready  | s_pin_level
//  result  | m_valid / m_ready      | valid, ready  | m_event_code, m_sampled_level,
//          |                        |               | m_last_of_tick
//  config  | psel penable pwrite .. | APB, pready=1 | paddr, pwdata, prdata
//
// A tick is processed in the cycle it is accepted; its events enter the queue at that edge
// and leave on the result channel after earlier events, one per cycle with m_ready high.
// Sustained rate is one tick per cycle with m_ready high while ticks average at most one
// event; a tick with down and long adds two, drained through the four-entry event queue.
// s_ready is low while the queue holds three or more events.
// Reset (aresetn, synchronous) clears the registers, the phase state and the queue.
module button_click_event_detector_top
    import bced_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_pin_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_code,
    output logic        m_sampled_level,
    output logic        m_last_of_tick,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t        cfg;
    ev_pair_t    evs;
    ev_t         head;
    evq_status_t q_status;
    logic        step;
    logic        pop;

    assign pready  = 1'b1;
    assign s_ready = (q_status.level <= EVQ_CW'(2));
    assign step    = s_valid & s_ready;
    assign m_valid = (q_status.level != '0);
    assign pop     = m_valid & m_ready;

    assign m_event_code    = head.code;
    assign m_sampled_level = head.level;
    assign m_last_of_tick  = head.last;

    bced_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    bced_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .pin_level (s_pin_level),
        .cfg       (cfg),
        .evs       (evs)
    );

    bced_evq u_evq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (evs),
        .pop     (pop),
        .head    (head),
        .status  (q_status)
    );

`ifndef SYNTHESIS
    // Queue never overflows
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.level <= EVQ_CW'(EVQ_DEPTH))
        else $error("event queue overflow");

    // No events are produced without an accepted tick
    a_push_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |-> (evs.cnt == 2'd0))
        else $error("events pushed without accepted tick");

    // A two-event tick is always down followed by long
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (evs.cnt == 2'd2) |-> (evs.first.code == EV_DOWN && evs.second.code == EV_LONG
                               && !evs.first.last && evs.second.last))
        else $error("bad event pair");

    // Fill level follows push and pop
    a_level_track: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (q_status.level == $past(q_status.level) + EVQ_CW'($past(evs.cnt))
             - EVQ_CW'($past(pop))))
        else $error("queue level mismatch");
`endif

endmodule
